// ===== rtl/two_level_inclusive_lru_cache_macros.svh =====
// assertion macros for the two-level inclusive lru cache
// expects i_clk and i_rst_n in the scope of use
`ifndef TWO_LEVEL_INCLUSIVE_LRU_CACHE_MACROS_SVH
`define TWO_LEVEL_INCLUSIVE_LRU_CACHE_MACROS_SVH

// same-cycle implication
`define TLC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define TLC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/tlc_pkg.sv =====
// shared types and constants for the two-level inclusive lru cache
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

    localparam int RANK_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L1_SET_BITS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L1_WAY_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_L2_SET_BITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_L2_WAY_BITS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE = 3'd5;

    localparam logic [1:0] OUT_L1_HIT = 2'd0;
    localparam logic [1:0] OUT_L2_HIT = 2'd1;
    localparam logic [1:0] OUT_MEMORY = 2'd2;

    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        config_error;
        logic [31:0] access_total;
        logic [31:0] l1_miss_total;
        logic [31:0] l2_miss_total;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/tlc_store.sv =====
// one tag store: line memory with registered read and per-line written flags
// depends on tlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlc_store import tlc_pkg::*; #(
    parameter int LINES = 64,
    parameter int AW    = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_clear,
    input  wire logic [RANK_W-1:0]                    i_way_mask,
    input  wire logic [(LINES > 1 ? $clog2(LINES) : 1)-1:0] i_line,
    input  wire logic                                 i_we,
    input  wire logic [AW+RANK_W+1:0]                 i_wdata,
    output logic      [AW+RANK_W+1:0]                 o_rdata
);

    localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WW = AW + RANK_W + 2;

    logic [WW-1:0]    mem [LINES];
    logic [LINES-1:0] r_written;
    logic [WW-1:0]    r_data;
    logic [IW-1:0]    r_line;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_line] <= i_wdata;
        end
        r_data <= mem[i_line];
        r_line <= i_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_written <= '0;
        end else if (i_we) begin
            r_written[i_line] <= 1'b1;
        end
    end

    // never-written line reads as reset: empty, clean, rank = way index
    always_comb begin
        if (r_written[r_line]) begin
            o_rdata = r_data;
        end else begin
            o_rdata = {{AW{1'b0}}, 1'b0, 1'b0, RANK_W'(r_line) & i_way_mask};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/two_level_inclusive_lru_cache.sv =====
// Two-level inclusive write-back cache model with true-LRU replacement. One
// word (read or write of a byte address) is taken at a time; o_stall is high
// until its result is registered. A shared way-scan unit walks one set of one
// store, a read phase then an examine/write phase per way; an access is one
// pass for the L1 lookup plus further passes: L1 hit 2 passes, L2 hit 3 to
// 5, miss with fill up to 7 passes. Bad geometry skips all passes and returns
// config_error.
// Writing any geometry register empties both stores at once; counters stay.
// depends on tlc_pkg, tlc_store and the macro header
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_inclusive_lru_cache_macros.svh"

module two_level_inclusive_lru_cache import tlc_pkg::*; #(
    parameter int ADDR_WIDTH = 32,
    parameter int L1_LINES   = 64,
    parameter int L2_LINES   = 256,
    parameter int MAX_WAYS   = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire t_in_word              i_word,
    output logic                       o_stall,
    output logic                       o_valid,
    output t_out_word                  o_word,
    input  wire logic                  i_stall,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = ADDR_WIDTH;
    localparam int WW  = AW + RANK_W + 2;
    localparam int I1W = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
    localparam int I2W = (L2_LINES > 1) ? $clog2(L2_LINES) : 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_L1SCAN  = 4'd1;
    localparam logic [3:0] S_L1TOUCH = 4'd2;
    localparam logic [3:0] S_L2SCAN  = 4'd3;
    localparam logic [3:0] S_H_FILL1 = 4'd4;
    localparam logic [3:0] S_H_MARK  = 4'd5;
    localparam logic [3:0] S_H_TOUCH = 4'd6;
    localparam logic [3:0] S_M_FILL2 = 4'd7;
    localparam logic [3:0] S_M_INV   = 4'd8;
    localparam logic [3:0] S_M_SCAN1 = 4'd9;
    localparam logic [3:0] S_M_FILL1 = 4'd10;
    localparam logic [3:0] S_M_MARK  = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_SCAN = 2'd1;
    localparam logic [1:0] K_UPD  = 2'd2;
    localparam logic [1:0] K_MOD  = 2'd3;

    // config
    logic [3:0] r_block_bits;
    logic [2:0] r_l1_sb;
    logic [1:0] r_l1_wb;
    logic [3:0] r_l2_sb;
    logic [1:0] r_l2_wb;
    logic       r_wa;
    logic       cfg_geo;

    // sequencer
    logic [3:0]  r_state;
    logic [3:0]  pass_next;
    logic [2:0]  r_way;
    logic        r_ph;
    logic        r_wr;
    logic [AW-1:0] r_key;
    logic [1:0]  r_outcome;
    logic        r_err;
    logic [31:0] r_acc_cnt;
    logic [31:0] r_l1m_cnt;
    logic [31:0] r_l2m_cnt;
    logic        r_ovalid;
    t_out_word   r_oword;

    // scan results, one set per store
    logic          r_hit   [2];
    logic [2:0]    r_hway  [2];
    logic [2:0]    r_hrank [2];
    logic [1:0]    r_vcls  [2];
    logic [2:0]    r_vway  [2];
    logic [2:0]    r_vrank [2];
    logic          r_vvalid[2];
    logic          r_vdirty[2];
    logic [AW-1:0] r_vblk  [2];

    // pass datapath
    logic [1:0]    p_kind;
    logic          p_sel;
    logic          p_vict;
    logic          p_inv;
    logic [AW-1:0] p_key;
    logic [2:0]    m1, m2, wmask;
    logic          last_way;
    logic [15:0]   l1_set, l2_set;
    logic [31:0]   l1_line32, l2_line32;
    logic [WW-1:0] l1_rd, l2_rd, rd, wdata;
    logic [AW-1:0] rd_blk;
    logic          rd_valid, rd_dirty;
    logic [2:0]    rd_rank;
    logic          match;
    logic          cur_hit, fin_hit;
    logic [1:0]    cur_cls, cls;
    logic [2:0]    tw, oldr, nrank;
    logic [AW-1:0] nblk;
    logic          nvalid, ndirty;
    logic          we, l1_we, l2_we;
    logic          alloc;
    logic          geom_ok;
    logic [31:0]   l1_need, l2_need;
    logic [AW+31:0] a_ext;
    logic [AW-1:0] key_in;

    assign cfg_geo = i_cfg_we && (i_cfg_index == REG_BLOCK_BITS ||
        i_cfg_index == REG_L1_SET_BITS || i_cfg_index == REG_L1_WAY_BITS ||
        i_cfg_index == REG_L2_SET_BITS || i_cfg_index == REG_L2_WAY_BITS);

    assign a_ext  = {{AW{1'b0}}, i_word.address};
    assign key_in = a_ext[AW-1:0] >> r_block_bits;

    assign l1_need = 32'd1 << ({2'b0, r_l1_sb} + {3'b0, r_l1_wb});
    assign l2_need = 32'd1 << ({1'b0, r_l2_sb} + {3'b0, r_l2_wb});
    assign geom_ok = (l1_need <= 32'(L1_LINES)) && ((32'd1 << r_l1_wb) <= 32'(MAX_WAYS))
                  && (l2_need <= 32'(L2_LINES)) && ((32'd1 << r_l2_wb) <= 32'(MAX_WAYS));

    assign alloc = (r_wr != OP_WRITE) || r_wa;

    always_comb begin
        p_kind = K_NONE;
        p_sel  = 1'b0;
        p_vict = 1'b0;
        p_inv  = 1'b0;
        case (r_state)
            S_L1SCAN:  begin p_kind = K_SCAN; end
            S_L1TOUCH: begin p_kind = K_UPD; end
            S_L2SCAN:  begin p_kind = K_SCAN; p_sel = 1'b1; end
            S_H_FILL1: begin p_kind = K_UPD;  p_vict = 1'b1; end
            S_H_MARK:  begin p_kind = K_MOD;  p_sel = 1'b1; end
            S_H_TOUCH: begin p_kind = K_UPD;  p_sel = 1'b1; end
            S_M_FILL2: begin p_kind = K_UPD;  p_sel = 1'b1; p_vict = 1'b1; end
            S_M_INV:   begin p_kind = K_MOD;  p_inv = 1'b1; end
            S_M_SCAN1: begin p_kind = K_SCAN; end
            S_M_FILL1: begin p_kind = K_UPD;  p_vict = 1'b1; end
            S_M_MARK:  begin p_kind = K_MOD;  p_sel = 1'b1; end
            default:   begin p_kind = K_NONE; end
        endcase
    end

    assign p_key    = (p_kind == K_MOD) ? r_vblk[~p_sel] : r_key;
    assign m1       = (3'd1 << r_l1_wb) - 3'd1;
    assign m2       = (3'd1 << r_l2_wb) - 3'd1;
    assign wmask    = p_sel ? m2 : m1;
    assign last_way = (r_way == wmask);

    assign l1_set    = p_key[15:0] & ((16'd1 << r_l1_sb) - 16'd1);
    assign l2_set    = p_key[15:0] & ((16'd1 << r_l2_sb) - 16'd1);
    assign l1_line32 = ({16'b0, l1_set} << r_l1_wb) | {29'b0, r_way};
    assign l2_line32 = ({16'b0, l2_set} << r_l2_wb) | {29'b0, r_way};

    assign rd       = p_sel ? l2_rd : l1_rd;
    assign rd_blk   = rd[WW-1 -: AW];
    assign rd_valid = rd[RANK_W+1];
    assign rd_dirty = rd[RANK_W];
    assign rd_rank  = rd[RANK_W-1:0];
    assign match    = rd_valid && (rd_blk == p_key);

    assign cur_hit = (r_way != 3'd0) && r_hit[p_sel];
    assign fin_hit = cur_hit || match;
    assign cur_cls = (r_way == 3'd0) ? 2'd0 : r_vcls[p_sel];
    assign cls     = !rd_valid ? 2'd3 : ((rd_rank == 3'd0) ? 2'd2 : 2'd1);

    always_comb begin
        tw     = p_vict ? r_vway[p_sel]  : r_hway[p_sel];
        oldr   = p_vict ? r_vrank[p_sel] : r_hrank[p_sel];
        nblk   = rd_blk;
        nvalid = rd_valid;
        ndirty = rd_dirty;
        nrank  = rd_rank;
        we     = 1'b0;
        if (p_kind == K_UPD) begin
            we = r_ph;
            if (r_way == tw) begin
                nblk   = p_vict ? r_key : rd_blk;
                nvalid = 1'b1;
                if (p_vict) begin
                    ndirty = !p_sel && (r_wr == OP_WRITE);
                end else if (p_sel) begin
                    ndirty = rd_dirty || ((r_wr == OP_WRITE) && !r_wa);
                end else begin
                    ndirty = rd_dirty || (r_wr == OP_WRITE);
                end
                nrank = wmask;
            end else if (rd_rank > oldr) begin
                nrank = rd_rank - 3'd1;
            end
        end else if (p_kind == K_MOD) begin
            we = r_ph && match;
            if (p_inv) begin
                nvalid = 1'b0;
                ndirty = 1'b0;
            end else begin
                ndirty = 1'b1;
            end
        end
    end

    assign wdata = {nblk, nvalid, ndirty, nrank};
    assign l1_we = we && !p_sel;
    assign l2_we = we && p_sel;

    always_comb begin
        pass_next = S_DONE;
        case (r_state)
            S_L1SCAN:  pass_next = fin_hit ? S_L1TOUCH : S_L2SCAN;
            S_L2SCAN:  begin
                if (fin_hit) begin
                    pass_next = alloc ? S_H_FILL1 : S_H_TOUCH;
                end else begin
                    pass_next = alloc ? S_M_FILL2 : S_DONE;
                end
            end
            S_H_FILL1: pass_next = (r_vvalid[0] && r_vdirty[0]) ? S_H_MARK : S_H_TOUCH;
            S_H_MARK:  pass_next = S_H_TOUCH;
            S_M_FILL2: pass_next = r_vvalid[1] ? S_M_INV : S_M_SCAN1;
            S_M_INV:   pass_next = S_M_SCAN1;
            S_M_SCAN1: pass_next = S_M_FILL1;
            S_M_FILL1: pass_next = (r_vvalid[0] && r_vdirty[0]) ? S_M_MARK : S_DONE;
            default:   pass_next = S_DONE;
        endcase
    end

    tlc_store #(.LINES(L1_LINES), .AW(AW)) u_l1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_geo),
        .i_way_mask (m1),
        .i_line     (l1_line32[I1W-1:0]),
        .i_we       (l1_we),
        .i_wdata    (wdata),
        .o_rdata    (l1_rd)
    );

    tlc_store #(.LINES(L2_LINES), .AW(AW)) u_l2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_geo),
        .i_way_mask (m2),
        .i_line     (l2_line32[I2W-1:0]),
        .i_we       (l2_we),
        .i_wdata    (wdata),
        .o_rdata    (l2_rd)
    );

    // scan capture
    always_ff @(posedge i_clk) begin
        if (r_ph && p_kind == K_SCAN) begin
            r_hit[p_sel] <= fin_hit;
            if (match && !cur_hit) begin
                r_hway[p_sel]  <= r_way;
                r_hrank[p_sel] <= rd_rank;
            end
            if (cls > cur_cls) begin
                r_vcls[p_sel]   <= cls;
                r_vway[p_sel]   <= r_way;
                r_vrank[p_sel]  <= rd_rank;
                r_vvalid[p_sel] <= rd_valid;
                r_vdirty[p_sel] <= rd_valid && rd_dirty;
                r_vblk[p_sel]   <= rd_blk;
            end else if (r_way == 3'd0) begin
                r_vcls[p_sel] <= cur_cls;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bits <= 4'd2;
            r_l1_sb      <= '0;
            r_l1_wb      <= '0;
            r_l2_sb      <= '0;
            r_l2_wb      <= '0;
            r_wa         <= 1'b0;
            r_state      <= S_IDLE;
            r_way        <= '0;
            r_ph         <= 1'b0;
            r_acc_cnt    <= '0;
            r_l1m_cnt    <= '0;
            r_l2m_cnt    <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCK_BITS:     r_block_bits <= i_cfg_data;
                    REG_L1_SET_BITS:    r_l1_sb      <= i_cfg_data[2:0];
                    REG_L1_WAY_BITS:    r_l1_wb      <= i_cfg_data[1:0];
                    REG_L2_SET_BITS:    r_l2_sb      <= i_cfg_data;
                    REG_L2_WAY_BITS:    r_l2_wb      <= i_cfg_data[1:0];
                    REG_WRITE_ALLOCATE: r_wa         <= i_cfg_data[0];
                    default:            r_wa         <= r_wa;
                endcase
            end
            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_wr      <= i_word.operation;
                        r_key     <= key_in;
                        r_way     <= '0;
                        r_ph      <= 1'b0;
                        r_outcome <= OUT_L1_HIT;
                        if (geom_ok) begin
                            r_err <= 1'b0;
                            if (r_acc_cnt != '1) begin
                                r_acc_cnt <= r_acc_cnt + 32'd1;
                            end
                            r_state <= S_L1SCAN;
                        end else begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid                <= 1'b1;
                        r_oword.outcome         <= r_outcome;
                        r_oword.config_error    <= r_err;
                        r_oword.access_total    <= r_acc_cnt;
                        r_oword.l1_miss_total   <= r_l1m_cnt;
                        r_oword.l2_miss_total   <= r_l2m_cnt;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    if (p_kind == K_NONE) begin
                        r_state <= S_IDLE;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (last_way) begin
                            r_way   <= '0;
                            r_state <= pass_next;
                            if (r_state == S_L1SCAN && !fin_hit && r_l1m_cnt != '1) begin
                                r_l1m_cnt <= r_l1m_cnt + 32'd1;
                            end
                            if (r_state == S_L2SCAN) begin
                                if (fin_hit) begin
                                    r_outcome <= OUT_L2_HIT;
                                end else begin
                                    r_outcome <= OUT_MEMORY;
                                    if (r_l2m_cnt != '1) begin
                                        r_l2m_cnt <= r_l2m_cnt + 32'd1;
                                    end
                                end
                            end
                        end else begin
                            r_way <= r_way + 3'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

    `TLC_ASSERT_NXT(a_accept_busy, i_valid && !o_stall, r_state != S_IDLE, "accept left sequencer idle")
    `TLC_ASSERT_NOW(a_we_phase, l1_we || l2_we, r_ph && p_kind != K_SCAN, "store write outside execute")
    `TLC_ASSERT_NOW(a_cnt_order, o_valid, (o_word.l2_miss_total <= o_word.l1_miss_total) && (o_word.l1_miss_total <= o_word.access_total), "miss totals out of order")
    `TLC_ASSERT_NOW(a_err_outcome, o_valid && o_word.config_error, o_word.outcome == OUT_L1_HIT, "config error with outcome")

endmodule

`default_nettype wire
